### design/prc_pkg.sv
`timescale 1ns / 1ps
package prc_pkg;
   localparam int MAX_VERTICES = 1024;
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int ROW_W = 10;
   localparam int EPOCH_W = 8;
   localparam int DIV_W = 64;
   localparam int DEG_W = 20;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_WEIGHT = 2'd1;
   localparam logic [1:0] OP_EDGE = 2'd2;
   localparam logic [1:0] OP_END = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_PERSONALIZED = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_WEIGHTS = 2'd3;

   localparam logic [16:0] DAMP_ONE = 17'd65536;

   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr;
      logic vtx_we;
      logic [ADDR_W-1:0] vtx_addr;
      logic [31:0] vtx_rank;
      logic [DEG_W-1:0] vtx_degree;
      logic wgt_we;
      logic [ADDR_W-1:0] wgt_addr;
      logic [EPOCH_W-1:0] wgt_tag;
      logic [31:0] wgt_value;
   } prc_mem_ctl_type;
endpackage

### design/prc_div.sv
`timescale 1ns / 1ps
module prc_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [prc_pkg::DIV_W-1:0] dividend,
   input logic [prc_pkg::DEG_W-1:0] divisor,
   output logic done,
   output logic [prc_pkg::DIV_W-1:0] quotient
);
   import prc_pkg::*;

   logic active_ff;
   logic done_ff;
   logic [$clog2(DIV_W)-1:0] count_ff;
   logic [DEG_W-1:0] rem_ff;
   logic [DEG_W-1:0] dsor_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DEG_W:0] shifted;
   logic fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits = shifted >= {1'b0, dsor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            count_ff <= '0;
            rem_ff <= '0;
            dsor_ff <= divisor;
            quo_ff <= dividend;
         end else if (active_ff) begin
            rem_ff <= fits ? DEG_W'(shifted - {1'b0, dsor_ff}) : shifted[DEG_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            count_ff <= count_ff + 1'b1;
            if (count_ff == '1) begin
               active_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

### design/prc_tables.sv
`timescale 1ns / 1ps
module prc_tables (
   input logic clock,
   input prc_pkg::prc_mem_ctl_type ctl,
   output logic [31:0] rank_rd,
   output logic [prc_pkg::DEG_W-1:0] degree_rd,
   output logic [prc_pkg::EPOCH_W-1:0] tag_rd,
   output logic [31:0] weight_rd
);
   import prc_pkg::*;

   logic [31:0] rank_mem [MAX_VERTICES];
   logic [DEG_W-1:0] degree_mem [MAX_VERTICES];
   logic [EPOCH_W+31:0] weight_mem [MAX_VERTICES];
   logic [31:0] rank_ff;
   logic [DEG_W-1:0] degree_ff;
   logic [EPOCH_W+31:0] weight_ff;

   always_ff @(posedge clock) begin
      if (ctl.vtx_we) begin
         rank_mem[ctl.vtx_addr] <= ctl.vtx_rank;
         degree_mem[ctl.vtx_addr] <= ctl.vtx_degree;
      end
      rank_ff <= rank_mem[ctl.rd_addr];
      degree_ff <= degree_mem[ctl.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.wgt_we) begin
         weight_mem[ctl.wgt_addr] <= {ctl.wgt_tag, ctl.wgt_value};
      end
      weight_ff <= weight_mem[ctl.rd_addr];
   end

   assign rank_rd = rank_ff;
   assign degree_rd = degree_ff;
   assign tag_rd = weight_ff[EPOCH_W+31:32];
   assign weight_rd = weight_ff[31:0];
endmodule

### design/pagerank_sparse_column_update.sv
`timescale 1ns / 1ps
// One PageRank column step in fixed point. A word is taken when start is high
// and busy low; busy stays high while a word is worked on. Load words are
// written in the accepting cycle and leave busy low; weight words run S_WGT.
// Edge words run S_EREAD, S_ETERM, S_ESCALE and S_EACC, plus S_EWLO and S_EWHI
// when weights are used and the row carries a mark, and the bit-serial divider
// (S_EDIV) when the row's degree is nonzero. End-column words run S_NLO, S_NHI,
// S_NTELE and S_NOUT, plus the same divider (S_NDIV) with the uniform share.
// The result appears on rsp_* for exactly one cycle with rsp_strobe; it cannot
// be held off. Weight marks are kept as an 8-bit column tag in the weight memory:
// after reset, and after every 255th end-column word, a clearing pass over all
// 1024 entries runs with busy high. Configuration writes are taken anytime.
module pagerank_sparse_column_update (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_opcode,
   input logic [9:0] req_row_index,
   input logic [31:0] req_old_rank,
   input logic [19:0] req_out_degree,
   input logic [31:0] req_edge_value,
   input logic [31:0] req_edge_weight,
   input logic [31:0] req_personal_share,
   output logic rsp_strobe,
   output logic [31:0] rsp_new_rank,
   output logic [15:0] rsp_column_number,
   output logic rsp_saturated,
   input logic csr_we,
   input logic [prc_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [prc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import prc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_SWEEP, S_WGT, S_EREAD, S_ETERM, S_EWLO, S_EWHI, S_ESCALE,
      S_EDIV, S_EACC, S_NLO, S_NHI, S_NTELE, S_NDIV, S_NOUT
   } state_type;

   state_type state_ff;
   logic [16:0] damping_ff;
   logic [10:0] vcount_ff;
   logic use_pers_ff;
   logic use_wgt_ff;
   logic [ADDR_W-1:0] sweep_ff;
   logic [EPOCH_W-1:0] epoch_ff;
   logic [63:0] sum_ff;
   logic clipped_ff;
   logic [15:0] counter_ff;
   logic [ADDR_W-1:0] row_ff;
   logic [31:0] value_ff;
   logic [31:0] share_ff;
   logic [31:0] wdata_ff;
   logic [63:0] prod_ff;
   logic [63:0] lo_ff;
   logic [63:0] term_ff;
   logic [DEG_W-1:0] deg_ff;
   logic [31:0] wgt_ff;
   logic present_ff;
   logic [31:0] damped_ff;
   logic end_clip_ff;
   logic [32:0] tele_ff;
   logic rsp_strobe_ff;
   logic [31:0] rsp_rank_ff;
   logic [15:0] rsp_col_ff;
   logic rsp_sat_ff;

   prc_mem_ctl_type mem_ctl;
   logic [31:0] rank_rd;
   logic [DEG_W-1:0] degree_rd;
   logic [EPOCH_W-1:0] tag_rd;
   logic [31:0] weight_rd;
   logic div_start;
   logic [DIV_W-1:0] div_dividend;
   logic div_done;
   logic [DIV_W-1:0] div_quot;
   logic accept;
   logic in_table;
   logic [16:0] damp_eff;
   logic [16:0] comp;
   logic [DEG_W-1:0] vc_eff;
   logic [47:0] whi;
   logic [48:0] nhi;
   logic [64:0] nsum;
   logic [64:0] acc;
   logic [33:0] total;

   prc_tables u_tables (
      .clock(clock), .ctl(mem_ctl), .rank_rd(rank_rd), .degree_rd(degree_rd),
      .tag_rd(tag_rd), .weight_rd(weight_rd)
   );

   prc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(state_ff == S_ESCALE ? deg_ff : vc_eff), .done(div_done),
      .quotient(div_quot)
   );

   always_comb begin
      accept = start && (state_ff == S_IDLE);
      in_table = 32'(req_row_index) < 32'(MAX_VERTICES);
      damp_eff = (damping_ff > DAMP_ONE) ? DAMP_ONE : damping_ff;
      comp = DAMP_ONE - damp_eff;
      vc_eff = (vcount_ff == '0) ? DEG_W'(1) : DEG_W'(vcount_ff);
      whi = 48'(prod_ff[63:48] * wgt_ff);
      nhi = 49'(sum_ff[63:32] * damp_eff);
      nsum = {1'b0, nhi[47:0], 16'b0} + {17'b0, lo_ff[63:16]};
      acc = {1'b0, sum_ff} + {1'b0, term_ff};
      total = {2'b0, damped_ff} + {1'b0, tele_ff};
      div_start = (state_ff == S_ESCALE && deg_ff != '0)
         || (state_ff == S_NTELE && !use_pers_ff);
      div_dividend = (state_ff == S_ESCALE) ? term_ff : DIV_W'({comp, 14'b0});

      mem_ctl.rd_addr = ADDR_W'(req_row_index);
      mem_ctl.vtx_we = accept && req_opcode == OP_LOAD && in_table;
      mem_ctl.vtx_addr = ADDR_W'(req_row_index);
      mem_ctl.vtx_rank = req_old_rank;
      mem_ctl.vtx_degree = req_out_degree;
      mem_ctl.wgt_we = 1'b0;
      mem_ctl.wgt_addr = row_ff;
      mem_ctl.wgt_tag = epoch_ff;
      mem_ctl.wgt_value = wdata_ff;
      if (state_ff == S_SWEEP) begin
         mem_ctl.wgt_we = 1'b1;
         mem_ctl.wgt_addr = sweep_ff;
         mem_ctl.wgt_tag = '0;
      end else if (state_ff == S_WGT) begin
         mem_ctl.wgt_we = tag_rd != epoch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         damping_ff <= 17'd55706;
         vcount_ff <= 11'd1024;
         use_pers_ff <= 1'b0;
         use_wgt_ff <= 1'b0;
         sweep_ff <= '0;
         epoch_ff <= EPOCH_W'(1);
         sum_ff <= '0;
         clipped_ff <= 1'b0;
         counter_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_DAMPING: damping_ff <= csr_wdata;
               CSR_VERTEX_COUNT: vcount_ff <= csr_wdata[10:0];
               CSR_USE_PERSONALIZED: use_pers_ff <= csr_wdata[0];
               CSR_USE_WEIGHTS: use_wgt_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  row_ff <= ADDR_W'(req_row_index);
                  value_ff <= req_edge_value;
                  share_ff <= req_personal_share;
                  wdata_ff <= req_edge_weight;
                  case (req_opcode)
                     OP_WEIGHT: if (in_table) state_ff <= S_WGT;
                     OP_EDGE: if (in_table) state_ff <= S_EREAD;
                     OP_END: state_ff <= S_NLO;
                     default: ;
                  endcase
               end
            end
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == ADDR_W'(MAX_VERTICES - 1)) state_ff <= S_IDLE;
            end
            S_WGT: state_ff <= S_IDLE;
            S_EREAD: begin
               prod_ff <= 64'(rank_rd * value_ff);
               deg_ff <= degree_rd;
               wgt_ff <= weight_rd;
               present_ff <= tag_rd == epoch_ff;
               state_ff <= S_ETERM;
            end
            S_ETERM: begin
               if (use_wgt_ff && present_ff) begin
                  state_ff <= S_EWLO;
               end else begin
                  term_ff <= use_wgt_ff ? 64'b0 : {16'b0, prod_ff[63:16]};
                  state_ff <= S_ESCALE;
               end
            end
            S_EWLO: begin
               lo_ff <= 64'(prod_ff[47:16] * wgt_ff);
               state_ff <= S_EWHI;
            end
            S_EWHI: begin
               term_ff <= {whi, 16'b0} + {16'b0, lo_ff[63:16]};
               state_ff <= S_ESCALE;
            end
            S_ESCALE: state_ff <= (deg_ff != '0) ? S_EDIV : S_EACC;
            S_EDIV: begin
               if (div_done) begin
                  term_ff <= div_quot;
                  state_ff <= S_EACC;
               end
            end
            S_EACC: begin
               sum_ff <= acc[64] ? '1 : acc[63:0];
               clipped_ff <= clipped_ff | acc[64];
               state_ff <= S_IDLE;
            end
            S_NLO: begin
               lo_ff <= 64'(sum_ff[31:0] * damp_eff);
               state_ff <= S_NHI;
            end
            S_NHI: begin
               if (nhi[48] || nsum[64] || nsum[63:32] != '0) begin
                  damped_ff <= '1;
                  end_clip_ff <= 1'b1;
               end else begin
                  damped_ff <= nsum[31:0];
                  end_clip_ff <= clipped_ff;
               end
               state_ff <= S_NTELE;
            end
            S_NTELE: begin
               if (use_pers_ff) begin
                  tele_ff <= 33'((49'(comp * share_ff)) >> 16);
                  state_ff <= S_NOUT;
               end else begin
                  state_ff <= S_NDIV;
               end
            end
            S_NDIV: begin
               if (div_done) begin
                  tele_ff <= div_quot[32:0];
                  state_ff <= S_NOUT;
               end
            end
            S_NOUT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_rank_ff <= (total[33:32] != '0) ? '1 : total[31:0];
               rsp_sat_ff <= end_clip_ff | (total[33:32] != '0);
               rsp_col_ff <= counter_ff;
               counter_ff <= counter_ff + 1'b1;
               sum_ff <= '0;
               clipped_ff <= 1'b0;
               if (epoch_ff == '1) begin
                  epoch_ff <= EPOCH_W'(1);
                  sweep_ff <= '0;
                  state_ff <= S_SWEEP;
               end else begin
                  epoch_ff <= epoch_ff + 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_new_rank = rsp_rank_ff;
   assign rsp_column_number = rsp_col_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("result without work");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back to back results");
   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0) else $error("column tag zero");
`endif
endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import prc_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 1200;

   typedef struct {
      logic [31:0] new_rank;
      logic [15:0] column_number;
      logic saturated;
   } column_result_type;

   class rank_scoreboard;
      logic [16:0] damping = 17'd55706;
      logic [10:0] vertex_count = 11'd1024;
      logic use_personalized = 1'b0;
      logic use_weights = 1'b0;
      logic [31:0] rank_table [MAX_VERTICES];
      logic [19:0] degree_table [MAX_VERTICES];
      logic [31:0] weight_table [MAX_VERTICES];
      bit weight_present [MAX_VERTICES];
      logic [63:0] column_sum = '0;
      logic [15:0] column_counter = '0;
      bit column_clipped = 0;
      column_result_type pending_results [$];
      int errors = 0;
      int results_seen = 0;
      int clipped_seen = 0;

      function void write_register(logic [1:0] index, logic [16:0] value);
         case (index)
            CSR_DAMPING: damping = value;
            CSR_VERTEX_COUNT: vertex_count = value[10:0];
            CSR_USE_PERSONALIZED: use_personalized = value[0];
            CSR_USE_WEIGHTS: use_weights = value[0];
            default: ;
         endcase
      endfunction

      function void note_word(logic [1:0] op, logic [9:0] row, logic [31:0] rank,
                              logic [19:0] degree, logic [31:0] value,
                              logic [31:0] weight, logic [31:0] share);
         logic [127:0] term;
         logic [64:0] next_sum;
         logic [16:0] d;
         logic [16:0] comp;
         logic [10:0] vc;
         logic [127:0] damped;
         logic [63:0] tele;
         logic [64:0] total;
         bit clip;
         column_result_type r;
         case (op)
            OP_LOAD: begin
               rank_table[row] = rank;
               degree_table[row] = degree;
            end
            OP_WEIGHT: begin
               if (!weight_present[row]) begin
                  weight_table[row] = weight;
                  weight_present[row] = 1;
               end
            end
            OP_EDGE: begin
               term = (128'(rank_table[row]) * value) >> 16;
               if (use_weights) begin
                  if (weight_present[row])
                     term = 128'(64'((term * weight_table[row]) >> 16));
                  else
                     term = '0;
               end
               if (degree_table[row] != 0) term = term / degree_table[row];
               next_sum = 65'(column_sum) + term[63:0];
               if (next_sum[64]) begin
                  column_sum = '1;
                  column_clipped = 1;
               end else begin
                  column_sum = next_sum[63:0];
               end
            end
            default: begin
               d = (damping > DAMP_ONE) ? DAMP_ONE : damping;
               comp = DAMP_ONE - d;
               vc = (vertex_count == 0) ? 11'd1 : vertex_count;
               clip = column_clipped;
               damped = (128'(column_sum) * d) >> 16;
               if (damped > 128'hFFFF_FFFF) begin
                  damped = 128'hFFFF_FFFF;
                  clip = 1;
               end
               if (use_personalized)
                  tele = (64'(comp) * share) >> 16;
               else
                  tele = (64'(comp) << 14) / vc;
               total = 65'(damped[31:0]) + tele;
               if (total > 65'hFFFF_FFFF) begin
                  total = 65'hFFFF_FFFF;
                  clip = 1;
               end
               r.new_rank = total[31:0];
               r.column_number = column_counter;
               r.saturated = clip;
               pending_results.push_back(r);
               column_counter++;
               column_sum = '0;
               column_clipped = 0;
               foreach (weight_present[i]) weight_present[i] = 0;
            end
         endcase
      endfunction

      function void check_word(logic [31:0] new_rank, logic [15:0] column_number,
                               logic saturated);
         column_result_type e;
         results_seen++;
         if (saturated) clipped_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word rank %h column %0d sat %0b",
                     $time, new_rank, column_number, saturated);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         if (new_rank !== e.new_rank) begin
            $display("%0t: new_rank expected %h actual %h", $time, e.new_rank, new_rank);
            errors++;
         end
         if (column_number !== e.column_number) begin
            $display("%0t: column_number expected %0d actual %0d", $time,
                     e.column_number, column_number);
            errors++;
         end
         if (saturated !== e.saturated) begin
            $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
                     saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_opcode = OP_LOAD;
   logic [9:0] req_row_index = '0;
   logic [31:0] req_old_rank = '0;
   logic [19:0] req_out_degree = '0;
   logic [31:0] req_edge_value = '0;
   logic [31:0] req_edge_weight = '0;
   logic [31:0] req_personal_share = '0;
   logic rsp_strobe;
   logic [31:0] rsp_new_rank;
   logic [15:0] rsp_column_number;
   logic rsp_saturated;
   logic csr_we = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rank_scoreboard ranks = new;
   int words_sent = 0;
   int cycle_count = 0;
   bit gaps_enabled = 1;
   int loaded_rows [$];

   always #2 clock = ~clock;

   pagerank_sparse_column_update dut (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pagerank_sparse_column_update verification failed");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_strobe)
         ranks.check_word(rsp_new_rank, rsp_column_number, rsp_saturated);

   task automatic idle_gap();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      n = 0;
      if (gaps_enabled) begin
         if (pick >= 92) n = $urandom_range(10, 40);
         else if (pick >= 60) n = $urandom_range(1, 3);
      end
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_word(logic [1:0] op, logic [9:0] row, logic [31:0] rank,
                            logic [19:0] degree, logic [31:0] value,
                            logic [31:0] weight, logic [31:0] share);
      req_opcode <= op;
      req_row_index <= row;
      req_old_rank <= rank;
      req_out_degree <= degree;
      req_edge_value <= value;
      req_edge_weight <= weight;
      req_personal_share <= share;
      start <= 1;
      do @(posedge clock); while (busy);
      ranks.note_word(op, row, rank, degree, value, weight, share);
      words_sent++;
      if (op == OP_LOAD) loaded_rows.push_back(row);
      idle_gap();
   endtask

   task automatic load_row(logic [9:0] row);
      logic [19:0] degree;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) degree = '0;
      else if (pick < 9) degree = 20'($urandom_range(1, 8));
      else degree = 20'($urandom);
      send_word(OP_LOAD, row, $urandom, degree, $urandom, $urandom, $urandom);
   endtask

   task automatic write_csr(logic [1:0] index, logic [16:0] value);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      ranks.write_register(index, value);
   endtask

   task automatic drain();
      start <= 0;
      while (ranks.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] wide_value();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF_FFFF;
         1: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_column();
      int nw;
      int ne;
      logic [9:0] row;
      logic [1:0] op;
      if ($urandom_range(0, 9) == 0) begin
         // stray word mixed into a column, edges only to loaded rows
         op = 2'($urandom);
         if (op == OP_EDGE)
            row = 10'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]);
         else
            row = 10'($urandom);
         send_word(op, row, $urandom, 20'($urandom), $urandom, $urandom, $urandom);
      end
      nw = $urandom_range(0, 4);
      ne = $urandom_range(0, 6);
      repeat ($urandom_range(0, 2)) load_row(10'($urandom));
      repeat (nw) begin
         row = 10'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]);
         send_word(OP_WEIGHT, row, $urandom, 20'($urandom), $urandom, wide_value(),
                   $urandom);
         if ($urandom_range(0, 3) == 0)
            send_word(OP_WEIGHT, row, $urandom, 20'($urandom), $urandom, $urandom,
                      $urandom);
      end
      repeat (ne) begin
         row = 10'(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)]);
         send_word(OP_EDGE, row, $urandom, 20'($urandom), wide_value(), $urandom,
                   $urandom);
      end
      send_word(OP_END, 10'($urandom), $urandom, 20'($urandom), $urandom, $urandom,
                wide_value());
   endtask

   initial begin
      logic [16:0] damp_settings [6];
      logic [10:0] count_settings [6];
      int phase;
      damp_settings = '{17'd0, 17'd65536, 17'd131071, 17'd55706, 17'd1, 17'd32768};
      count_settings = '{11'd1, 11'd2047, 11'd0, 11'd1024, 11'd3, 11'd1000};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_csr(CSR_DAMPING, 17'd65536);
      write_csr(CSR_VERTEX_COUNT, 17'd1);
      write_csr(CSR_USE_PERSONALIZED, 17'd1);
      write_csr(CSR_USE_WEIGHTS, 17'd1);
      // extremes, duplicate and missing weights, saturating sum
      send_word(OP_LOAD, 10'd0, 32'hFFFF_FFFF, 20'd0, '0, '0, '0);
      send_word(OP_LOAD, 10'd1023, 32'h0, 20'hFFFFF, '1, '1, '1);
      send_word(OP_LOAD, 10'd5, 32'hFFFF_FFFF, 20'd1, '0, '0, '0);
      send_word(OP_WEIGHT, 10'd0, '0, '0, '0, 32'hFFFF_FFFF, '0);
      send_word(OP_WEIGHT, 10'd0, '0, '0, '0, 32'h1, '0);
      send_word(OP_WEIGHT, 10'd1023, '0, '0, '0, 32'h0, '0);
      send_word(OP_EDGE, 10'd0, '0, '0, 32'hFFFF_FFFF, '0, '0);
      send_word(OP_EDGE, 10'd0, '0, '0, 32'hFFFF_FFFF, '0, '0);
      send_word(OP_EDGE, 10'd1023, '0, '0, 32'hFFFF_FFFF, '0, '0);
      send_word(OP_EDGE, 10'd5, '0, '0, 32'hFFFF_FFFF, '0, '0);
      send_word(OP_END, 10'd0, '0, '0, '0, '0, 32'hFFFF_FFFF);
      send_word(OP_EDGE, 10'd5, '0, '0, 32'h0001_0000, '0, '0);
      send_word(OP_END, 10'd1023, '0, '0, '0, '0, 32'h0);
      drain();
      write_csr(CSR_USE_WEIGHTS, 17'd0);
      write_csr(CSR_DAMPING, 17'd0);
      send_word(OP_EDGE, 10'd0, '0, '0, 32'hFFFF_FFFF, '0, '0);
      send_word(OP_END, 10'd0, '0, '0, '0, '0, 32'hFFFF_FFFF);
      drain();
      write_csr(CSR_USE_PERSONALIZED, 17'd0);
      send_word(OP_END, 10'd0, '0, '0, '0, '0, '0);

      phase = 0;
      while (words_sent < 1700) begin
         drain();
         write_csr(CSR_DAMPING, damp_settings[phase % 6]);
         write_csr(CSR_VERTEX_COUNT, 17'(count_settings[(phase / 2) % 6]));
         write_csr(CSR_USE_PERSONALIZED, 17'(phase % 3 == 1));
         write_csr(CSR_USE_WEIGHTS, 17'((phase / 3) % 2 == 0));
         gaps_enabled = phase % 4 != 3;
         repeat (6) load_row(10'($urandom));
         repeat (25) random_column();
         phase++;
      end
      drain();
      $display("sent %0d words over %0d setting phases; %0d result words checked, %0d clipped",
               words_sent, phase, ranks.results_seen, ranks.clipped_seen);
      if (ranks.errors == 0)
         $display("pagerank_sparse_column_update verification clean");
      else
         $display("pagerank_sparse_column_update verification failed");
      $finish;
   end
endmodule

### filelist.f
design/prc_pkg.sv
design/prc_div.sv
design/prc_tables.sv
design/pagerank_sparse_column_update.sv
test/testbench.sv
